[src/wdg_pkg.sv]
package wdg_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int THR_W     = 23;
    localparam int CNT_W     = 5;
    localparam int OFFSET_W  = 6;
    localparam int WIN_LEN   = 8;
    localparam int WIN_IDX_W = $clog2(WIN_LEN);
    localparam int SUM_W     = SAMPLE_W + WIN_IDX_W;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAR_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAR_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LOW  = 3'd4;

    // Wear status codes.
    localparam logic [1:0] ST_UNDECIDED = 2'd0;
    localparam logic [1:0] ST_WORN      = 2'd1;
    localparam logic [1:0] ST_REMOVED   = 2'd2;

    localparam logic [CNT_W-1:0]    COUNT_RESET  = 5'd10;
    localparam logic [1:0]          DIV_LAST     = 2'd3;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX   = 6'd32;
    localparam logic [SAMPLE_W:0]   QUIET_SPREAD = 25'd4000;
    localparam logic [SAMPLE_W-1:0] MIN_RESET    = 24'd300000;

    localparam logic [THR_W-1:0] WEAR_HIGH_RST = 23'd5000;
    localparam logic [THR_W-1:0] WEAR_LOW_RST  = 23'd4000;
    localparam logic [THR_W-1:0] GAIN_HIGH_RST = 23'd450000;
    localparam logic [THR_W-1:0] GAIN_LOW_RST  = 23'd150000;

    typedef struct packed {
        logic                 load;
        logic                 scan;
        logic                 scan_first;
        logic [WIN_IDX_W-1:0] scan_idx;
        logic                 track;
        logic                 thresh;
        logic                 commit;
    } t_cmd;

    typedef struct packed {
        logic diff_mode;
    } t_stat;

endpackage

[src/wdg_ctrl.sv]
module wdg_ctrl
    import wdg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_TRACK  = 3'd2;
    localparam logic [2:0] S_THRESH = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [WIN_IDX_W-1:0] r_idx, n_idx;
    logic                 r_out_valid, n_out_valid;
    logic                 w_accept;
    logic                 w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.scan_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = i_stat.diff_mode ? S_SCAN : S_THRESH;
                end
            end
            S_SCAN: begin
                o_cmd.scan       = 1'b1;
                o_cmd.scan_first = (r_idx == '0);
                n_idx            = r_idx + 1'b1;
                if (r_idx == WIN_IDX_W'(WIN_LEN - 1)) begin
                    n_state = S_TRACK;
                end
            end
            S_TRACK: begin
                o_cmd.track = 1'b1;
                n_state     = S_THRESH;
            end
            S_THRESH: begin
                o_cmd.thresh = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                // State moves only when the result register can take the result.
                if (w_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[src/wdg_dp.sv]
module wdg_dp
    import wdg_pkg::*;
#(
    parameter int COUNT_LIMIT = 20
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_wdata,
    input  logic [SAMPLE_W-1:0]  i_ambient_sample,
    input  logic [SAMPLE_W-1:0]  i_infrared_sample,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic [1:0]           o_status,
    output logic                 o_became_worn,
    output logic                 o_became_removed,
    output logic                 o_gain_write,
    output logic [OFFSET_W-1:0]  o_gain_offset
);

    localparam logic [CNT_W-1:0] CntLimit = CNT_W'(COUNT_LIMIT);
    localparam int TW = SAMPLE_W + 2;

    // Configuration registers.
    logic                r_diff_mode;
    logic [THR_W-1:0]    r_wear_high, r_wear_low, r_gain_high, r_gain_low;

    // Block state.
    logic [1:0]          r_wear, n_wear;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [1:0]          r_div, n_div;
    logic [OFFSET_W-1:0] r_off, n_off;
    logic [SAMPLE_W-1:0] r_win [WIN_LEN];
    logic [SAMPLE_W-1:0] r_tmin, r_tmax;

    // Per-item working registers.
    logic signed [SAMPLE_W-1:0] r_amb, r_ir;
    logic signed [SAMPLE_W-1:0] r_lo, r_hi;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [TW-1:0]       r_thr_hi, r_thr_lo;

    // Result register.
    logic [1:0]          r_o_status;
    logic                r_o_worn, r_o_removed, r_o_write;
    logic [OFFSET_W-1:0] r_o_off;

    logic signed [SAMPLE_W-1:0] w_entry;
    logic signed [SAMPLE_W:0]   w_spread;
    logic                       w_quiet;
    logic [SAMPLE_W-1:0]        w_mean;
    logic [SAMPLE_W:0]          w_rel_hi, w_rel_lo;
    logic                       w_relative;
    logic signed [TW-1:0]       w_ir_x;
    logic signed [SAMPLE_W:0]   w_amb_x;
    logic                       w_up, w_down, n_write;

    assign o_stat.diff_mode = r_diff_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_mode <= 1'b0;
            r_wear_high <= WEAR_HIGH_RST;
            r_wear_low  <= WEAR_LOW_RST;
            r_gain_high <= GAIN_HIGH_RST;
            r_gain_low  <= GAIN_LOW_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DIFF_MODE: r_diff_mode <= i_cfg_wdata[0];
                CFG_WEAR_HIGH: r_wear_high <= i_cfg_wdata;
                CFG_WEAR_LOW:  r_wear_low  <= i_cfg_wdata;
                CFG_GAIN_HIGH: r_gain_high <= i_cfg_wdata;
                CFG_GAIN_LOW:  r_gain_low  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Window scan: one entry per cycle into running min, max and sum.
    assign w_entry = $signed(r_win[i_cmd.scan_idx]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_amb <= $signed(i_ambient_sample);
            r_ir  <= $signed(i_infrared_sample);
        end
        if (i_cmd.scan) begin
            if (i_cmd.scan_first) begin
                r_lo  <= w_entry;
                r_hi  <= w_entry;
                r_sum <= SUM_W'(w_entry);
            end else begin
                if (w_entry < r_lo) r_lo <= w_entry;
                if (w_entry > r_hi) r_hi <= w_entry;
                r_sum <= r_sum + SUM_W'(w_entry);
            end
        end
    end

    // A quiet window has only positive entries, so the sum is positive and the
    // mean is a plain shift.
    assign w_spread = $signed({r_hi[SAMPLE_W-1], r_hi}) - $signed({r_lo[SAMPLE_W-1], r_lo});
    assign w_quiet  = (w_spread < $signed(QUIET_SPREAD)) && (r_lo > 0);
    assign w_mean   = r_sum[SUM_W-1:WIN_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_tmin <= MIN_RESET;
            r_tmax <= '0;
        end else begin
            if (i_cmd.load && r_diff_mode) begin
                for (int i = 0; i < WIN_LEN - 1; i++) begin
                    r_win[i] <= r_win[i + 1];
                end
                r_win[WIN_LEN-1] <= i_infrared_sample;
            end
            if (i_cmd.track && w_quiet && (w_mean != '0)) begin
                if (w_mean < r_tmin) r_tmin <= w_mean;
                if (w_mean > r_tmax) r_tmax <= w_mean;
            end
        end
    end

    // Thresholds, relative to the tracked minimum in diff mode with a wide range.
    assign w_rel_hi   = {1'b0, r_tmin} + (SAMPLE_W+1)'(r_wear_high);
    assign w_rel_lo   = {1'b0, r_tmin} + (SAMPLE_W+1)'(r_wear_low);
    assign w_relative = r_diff_mode && (r_tmax != '0) && (r_tmin != '0)
                        && ({1'b0, r_tmax} > w_rel_hi);

    always_ff @(posedge i_clk) begin
        if (i_cmd.thresh) begin
            if (w_relative) begin
                r_thr_hi <= $signed({1'b0, w_rel_hi});
                r_thr_lo <= $signed({1'b0, w_rel_lo});
            end else begin
                r_thr_hi <= $signed({3'b000, r_wear_high});
                r_thr_lo <= $signed({3'b000, r_wear_low});
            end
        end
    end

    assign w_ir_x  = TW'(r_ir);
    assign w_amb_x = (SAMPLE_W+1)'(r_amb);

    always_comb begin
        n_wear = r_wear;
        n_cnt  = r_cnt;
        if (w_ir_x > r_thr_hi) begin
            if (r_cnt >= CntLimit) begin
                n_cnt  = CntLimit;
                n_wear = ST_WORN;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end else if (w_ir_x < r_thr_lo) begin
            if (r_cnt == '0) begin
                n_wear = ST_REMOVED;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    assign w_up   = w_amb_x > $signed({2'b00, r_gain_high});
    assign w_down = !w_up && (w_amb_x < $signed({2'b00, r_gain_low}));

    always_comb begin
        n_div   = r_div;
        n_off   = r_off;
        n_write = 1'b0;
        if (n_wear == ST_WORN) begin
            if (w_up || w_down) begin
                if (r_div == DIV_LAST) begin
                    n_div = '0;
                    if (w_up && (r_off < OFFSET_MAX)) begin
                        n_off   = r_off + 1'b1;
                        n_write = 1'b1;
                    end else if (w_down && (r_off != '0)) begin
                        n_off   = r_off - 1'b1;
                        n_write = 1'b1;
                    end
                end else begin
                    n_div = r_div + 1'b1;
                end
            end
        end else begin
            n_div = '0;
            n_off = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wear <= ST_UNDECIDED;
            r_cnt  <= COUNT_RESET;
            r_div  <= '0;
            r_off  <= '0;
        end else if (i_cmd.commit) begin
            r_wear <= n_wear;
            r_cnt  <= n_cnt;
            r_div  <= n_div;
            r_off  <= n_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_status  <= n_wear;
            r_o_worn    <= (n_wear == ST_WORN) && (r_wear != ST_WORN);
            r_o_removed <= (n_wear == ST_REMOVED) && (r_wear != ST_REMOVED);
            r_o_write   <= n_write;
            r_o_off     <= n_off;
        end
    end

    assign o_status         = r_o_status;
    assign o_became_worn    = r_o_worn;
    assign o_became_removed = r_o_removed;
    assign o_gain_write     = r_o_write;
    assign o_gain_offset    = r_o_off;

endmodule

[src/wear_detect_and_gain_step_unit.sv]
// Channel   Direction  Transaction
// s_axis    in         one sample pair (ambient, infrared)
// m_axis    out        one result: status, transition pulses, gain step
// cfg       in         one register write, index 0..4, no read-back
//
// After an input, diff mode scans the sample window through one min/max/sum
// unit, then runs the track, threshold and decide steps; absolute mode runs
// only threshold and decide. The result is registered in the decide step,
// and a new input is taken only when idle. Reset is synchronous and active
// low and restores control, config, window, tracking, wear and gain state
// but not per-item or result data registers. A result waits in the output
// register under a stall while the next item is accepted and processed;
// the block holds in its last step until the output register is free.
module wear_detect_and_gain_step_unit
    import wdg_pkg::*;
#(
    parameter int COUNT_LIMIT = 20
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [23:0] ambient_sample, [47:24] infrared_sample
    input  logic [47:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [1:0] status, [2] became_worn, [3] became_removed, [4] gain_write,
    // [10:5] gain_offset, [15:11] zero
    output logic [15:0]          m_axis_tdata,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_wdata
);

    t_cmd                w_cmd;
    t_stat               w_stat;
    logic [1:0]          w_status;
    logic                w_worn, w_removed, w_write;
    logic [OFFSET_W-1:0] w_off;

    wdg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    wdg_dp #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_ambient_sample  (s_axis_tdata[23:0]),
        .i_infrared_sample (s_axis_tdata[47:24]),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_status          (w_status),
        .o_became_worn     (w_worn),
        .o_became_removed  (w_removed),
        .o_gain_write      (w_write),
        .o_gain_offset     (w_off)
    );

    assign m_axis_tdata = {5'b00000, w_off, w_write, w_removed, w_worn, w_status};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import wdg_pkg::*;

    localparam int COUNT_LIMIT    = 20;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic [THR_W-1:0]           THR_MAX    = '1;
    // No register lives at this index; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0]       CFG_SPARE  = 3'd7;

    typedef enum int {SEG_RISE, SEG_FALL, SEG_LEVEL, SEG_NOISE, SEG_MIXED} t_seg_kind;
    typedef enum int {AMB_ABOVE, AMB_BELOW, AMB_BETWEEN, AMB_ANY, AMB_MIXED} t_amb_kind;

    typedef struct packed {
        logic [OFFSET_W-1:0] gain_offset;
        logic                gain_write;
        logic                became_removed;
        logic                became_worn;
        logic [1:0]          status;
    } t_wear_result;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [23:0] ambient_sample, [47:24] infrared_sample
    logic [47:0]          s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [1:0] status, [2] became_worn, [3] became_removed, [4] gain_write,
    // [10:5] gain_offset, [15:11] zero
    logic [15:0]          m_axis_tdata;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [THR_W-1:0]     i_cfg_wdata   = '0;

    // Predicted register and state copy of the block.
    logic                       mode_diff;
    logic [THR_W-1:0]           thr_wear_high, thr_wear_low, thr_gain_high, thr_gain_low;
    logic [1:0]                 wear_state;
    logic [CNT_W-1:0]           debounce_cnt;
    logic [1:0]                 gain_div;
    logic [OFFSET_W-1:0]        gain_offset_q;
    logic signed [SAMPLE_W-1:0] ir_window [WIN_LEN];
    logic signed [SAMPLE_W-1:0] min_level, max_level;

    t_wear_result predicted_outcomes[$];
    int           fault_count  = 0;
    int           quiet_cycles = 0;
    int           hold_left    = 0;
    int           rx_wait      = 0;
    bit           hold_request = 1'b0;
    bit           steady       = 1'b0;

    wear_detect_and_gain_step_unit #(
        .COUNT_LIMIT(COUNT_LIMIT)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [SAMPLE_W-1:0] clamp24(input longint v);
        if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
        if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic longint jitter(input int unsigned span);
        return longint'($urandom_range(0, span));
    endfunction

    // Thresholds in force: relative to the tracked minimum once the tracked
    // range in diff mode is wider than the high threshold.
    function automatic void wear_limits(output longint hi, output longint lo);
        if (mode_diff && max_level > 0 && min_level > 0 &&
            longint'(max_level) > longint'(min_level) + longint'(thr_wear_high)) begin
            hi = longint'(min_level) + longint'(thr_wear_high);
            lo = longint'(min_level) + longint'(thr_wear_low);
        end else begin
            hi = longint'(thr_wear_high);
            lo = longint'(thr_wear_low);
        end
    endfunction

    function automatic void shift_window(input logic signed [SAMPLE_W-1:0] ir);
        longint total, lo_v, hi_v, mean;
        int i;
        for (i = 0; i < WIN_LEN - 1; i++) ir_window[i] = ir_window[i + 1];
        ir_window[WIN_LEN - 1] = ir;
        total = 0;
        lo_v  = ir_window[0];
        hi_v  = ir_window[0];
        for (i = 0; i < WIN_LEN; i++) begin
            total += ir_window[i];
            if (ir_window[i] < lo_v) lo_v = ir_window[i];
            if (ir_window[i] > hi_v) hi_v = ir_window[i];
        end
        // A noisy window yields no mean at all.
        mean = (hi_v - lo_v < longint'(QUIET_SPREAD) && lo_v > 0) ? total / WIN_LEN : 0;
        if (mean > 0 && mean < min_level) min_level = mean[SAMPLE_W-1:0];
        if (mean > 0 && mean > max_level) max_level = mean[SAMPLE_W-1:0];
    endfunction

    function automatic t_wear_result predict_sample(input logic signed [SAMPLE_W-1:0] amb,
                                                    input logic signed [SAMPLE_W-1:0] ir);
        t_wear_result r;
        logic [1:0]   prior;
        longint       hi, lo;
        logic         up, down;
        r     = '0;
        prior = wear_state;
        if (mode_diff) shift_window(ir);
        wear_limits(hi, lo);
        if (longint'(ir) > hi) begin
            if (debounce_cnt >= COUNT_LIMIT) begin
                debounce_cnt = CNT_W'(COUNT_LIMIT);
                wear_state   = ST_WORN;
            end else begin
                debounce_cnt++;
            end
        end else if (longint'(ir) < lo) begin
            if (debounce_cnt == 0) wear_state = ST_REMOVED;
            else debounce_cnt--;
        end

        if (wear_state == ST_WORN) begin
            up   = longint'(amb) > longint'(thr_gain_high);
            down = !up && (longint'(amb) < longint'(thr_gain_low));
            if (up || down) begin
                if (gain_div == DIV_LAST) begin
                    // The divider restarts even when the offset is pinned.
                    gain_div = '0;
                    if (up && gain_offset_q < OFFSET_MAX) begin
                        gain_offset_q++;
                        r.gain_write = 1'b1;
                    end else if (down && gain_offset_q > 0) begin
                        gain_offset_q--;
                        r.gain_write = 1'b1;
                    end
                end else begin
                    gain_div++;
                end
            end
        end else begin
            gain_div      = '0;
            gain_offset_q = '0;
        end

        r.status         = wear_state;
        r.became_worn    = (wear_state == ST_WORN) && (prior != ST_WORN);
        r.became_removed = (wear_state == ST_REMOVED) && (prior != ST_REMOVED);
        r.gain_offset    = gain_offset_q;
        return r;
    endfunction

    function automatic void note_fault(input string what, input logic [15:0] want_v,
                                       input logic [15:0] got_v);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, what, want_v, got_v);
    endfunction

    function automatic void check_outcome(input logic [15:0] data);
        t_wear_result want, got;
        if (predicted_outcomes.size() == 0) begin
            note_fault("result with nothing pending, tdata", 16'd0, data);
            return;
        end
        want = predicted_outcomes.pop_front();
        got  = t_wear_result'(data[10:0]);
        if (got.status !== want.status) note_fault("status", want.status, got.status);
        if (got.became_worn !== want.became_worn)
            note_fault("became_worn", want.became_worn, got.became_worn);
        if (got.became_removed !== want.became_removed)
            note_fault("became_removed", want.became_removed, got.became_removed);
        if (got.gain_write !== want.gain_write)
            note_fault("gain_write", want.gain_write, got.gain_write);
        if (got.gain_offset !== want.gain_offset)
            note_fault("gain_offset", want.gain_offset, got.gain_offset);
        if (data[15:11] !== 5'd0) note_fault("padding", 16'd0, data[15:11]);
    endfunction

    // Result side: checks each transaction and stalls for a random count
    // afterwards, or for a long stretch when a test asks for one.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            check_outcome(m_axis_tdata);
            rx_wait = steady ? 0 : $urandom_range(0, 3);
        end
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // Valid is only lowered when a gap follows, so back-to-back transactions
    // keep it high without a glitch.
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] amb,
                             input logic signed [SAMPLE_W-1:0] ir);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ir, amb};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted_outcomes.push_back(predict_sample(amb, ir));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (predicted_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_DIFF_MODE: mode_diff     = value[0];
            CFG_WEAR_HIGH: thr_wear_high = value;
            CFG_WEAR_LOW:  thr_wear_low  = value;
            CFG_GAIN_HIGH: thr_gain_high = value;
            CFG_GAIN_LOW:  thr_gain_low  = value;
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_ambient(input t_amb_kind k);
        case (k)
            AMB_ABOVE:   return clamp24(longint'(thr_gain_high) + 1 + jitter(200000));
            AMB_BELOW:   return clamp24(longint'(thr_gain_low) - 1 - jitter(200000));
            AMB_BETWEEN: return clamp24(longint'(thr_gain_low) + jitter(300000));
            default:     return 24'($urandom);
        endcase
    endfunction

    // Runs of infrared readings that push the debounce counter one way, sit
    // at a quiet level, or are plain noise, each with an ambient pattern.
    task automatic run_segments(input int count, input t_seg_kind seg_req,
                                input t_amb_kind amb_req);
        int                         sent, len, k, pick;
        t_seg_kind                  seg;
        t_amb_kind                  amb_sel;
        longint                     hi, lo, level;
        logic signed [SAMPLE_W-1:0] ir;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 9);
            if (seg_req != SEG_MIXED) seg = seg_req;
            else if (pick < 4) seg = SEG_RISE;
            else if (pick < 6) seg = SEG_FALL;
            else if (pick < 8) seg = SEG_LEVEL;
            else seg = SEG_NOISE;
            amb_sel = (amb_req == AMB_MIXED) ? t_amb_kind'($urandom_range(0, 3)) : amb_req;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 40);
            level = ($urandom_range(0, 3) == 0) ? jitter(4000) - 2000
                                                : longint'($urandom_range(1, 1 << 21));
            for (k = 0; k < len && sent < count; k++) begin
                wear_limits(hi, lo);
                case (seg)
                    SEG_RISE:  ir = clamp24(hi + 1 + jitter(3000));
                    SEG_FALL:  ir = clamp24(lo - 1 - jitter(3000));
                    SEG_LEVEL: ir = clamp24(level + jitter(3000));
                    default:   ir = 24'($urandom);
                endcase
                send_pair(pick_ambient(amb_sel), ir);
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        int k;
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair('0, '0);
        // Readings right at and around the default thresholds.
        send_pair(-24'sd1, 24'sd5001);
        send_pair('0, 24'sd5000);
        send_pair('0, 24'sd4000);
        send_pair('0, 24'sd3999);
        // Counter saturates, worn is declared, offset steps up, then down.
        for (k = 0; k < 16; k++) send_pair(SAMPLE_MAX, SAMPLE_MAX);
        for (k = 0; k < 4; k++) send_pair(SAMPLE_MIN, SAMPLE_MAX);
    endtask

    task automatic test_absolute_random();
        run_segments(50, SEG_MIXED, AMB_MIXED);
    endtask

    task automatic test_diff_mode();
        wait_idle();
        write_reg(CFG_DIFF_MODE, 23'd1);
        write_reg(CFG_WEAR_HIGH, WEAR_HIGH_RST);
        write_reg(CFG_WEAR_LOW, WEAR_LOW_RST);
        run_segments(80, SEG_MIXED, AMB_MIXED);
    endtask

    task automatic test_threshold_extremes();
        wait_idle();
        write_reg(CFG_DIFF_MODE, 23'd0);
        write_reg(CFG_WEAR_HIGH, THR_MAX);
        write_reg(CFG_WEAR_LOW, '0);
        write_reg(CFG_SPARE, 23'($urandom));
        run_segments(25, SEG_MIXED, AMB_MIXED);
        wait_idle();
        write_reg(CFG_WEAR_HIGH, '0);
        write_reg(CFG_WEAR_LOW, '0);
        write_reg(CFG_DIFF_MODE, 23'd1);
        run_segments(25, SEG_MIXED, AMB_MIXED);
    endtask

    // Drives the offset to both ends and a few samples beyond each.
    task automatic test_gain_bounds();
        logic [THR_W-1:0] high_v;
        wait_idle();
        high_v = 23'($urandom_range(0, 1 << 22));
        write_reg(CFG_DIFF_MODE, 23'd0);
        write_reg(CFG_WEAR_HIGH, WEAR_HIGH_RST);
        write_reg(CFG_WEAR_LOW, WEAR_LOW_RST);
        write_reg(CFG_GAIN_HIGH, high_v);
        write_reg(CFG_GAIN_LOW, 23'($urandom_range(0, high_v)));
        while (gain_offset_q != OFFSET_MAX) run_segments(8, SEG_RISE, AMB_ABOVE);
        run_segments(8, SEG_RISE, AMB_ABOVE);
        while (gain_offset_q != 0) run_segments(8, SEG_RISE, AMB_BELOW);
        run_segments(8, SEG_RISE, AMB_BELOW);
        wait_idle();
        write_reg(CFG_GAIN_HIGH, THR_MAX);
        write_reg(CFG_GAIN_LOW, THR_MAX);
        run_segments(20, SEG_RISE, AMB_MIXED);
    endtask

    task automatic test_output_stall();
        hold_request = 1'b1;
        run_segments(12, SEG_MIXED, AMB_MIXED);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        run_segments(30, SEG_MIXED, AMB_MIXED);
        steady = 1'b0;
    endtask

    task automatic test_random_settings();
        int round;
        for (round = 0; round < 2; round++) begin
            wait_idle();
            write_reg(CFG_DIFF_MODE, 23'($urandom_range(0, 1)));
            write_reg(CFG_WEAR_HIGH, 23'($urandom_range(0, 200000)));
            write_reg(CFG_WEAR_LOW, 23'($urandom_range(0, 200000)));
            write_reg(CFG_GAIN_HIGH, 23'($urandom));
            write_reg(CFG_GAIN_LOW, 23'($urandom));
            run_segments(25, SEG_MIXED, AMB_MIXED);
        end
    endtask

    initial begin
        mode_diff     = 1'b0;
        thr_wear_high = WEAR_HIGH_RST;
        thr_wear_low  = WEAR_LOW_RST;
        thr_gain_high = GAIN_HIGH_RST;
        thr_gain_low  = GAIN_LOW_RST;
        wear_state    = ST_UNDECIDED;
        debounce_cnt  = COUNT_RESET;
        gain_div      = '0;
        gain_offset_q = '0;
        foreach (ir_window[i]) ir_window[i] = '0;
        min_level     = MIN_RESET;
        max_level     = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_absolute_random();
        test_diff_mode();
        test_threshold_extremes();
        test_gain_bounds();
        test_output_stall();
        test_back_to_back();
        test_random_settings();
        wait_idle();

        if (fault_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
